@@ sv/srdc_pkg.sv @@
package srdc_pkg;

    localparam int DIFF_W     = 53;
    localparam int PROD_W     = 56;
    localparam int RATE_W     = 23;
    localparam int TIME_W     = 32;
    localparam int DEN_W      = 28;
    localparam int CNT_W      = 6;
    localparam int Q_W        = 7;
    localparam int Q_NUM_W    = 16;
    localparam int RATE_SUM_W = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 53;

    localparam logic [1:0] MODE_SHARE  = 2'd0;
    localparam logic [1:0] MODE_ADJUST = 2'd1;
    localparam logic [1:0] MODE_CHANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIFFICULTY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFFICULTY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_DIFFICULTY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_RESET_VALUE  = 3'd4;

    localparam logic [DIFF_W-1:0] MAX_DIFF_RESET   = '1;
    localparam logic [RATE_W-1:0] RATE_RESET_RESET = 23'd655360;

    localparam logic [PROD_W-1:0]  ONE_UNIT  = 56'd100000000;
    localparam logic [DEN_W-1:0]   TWO_UNITS = 28'd200000000;
    localparam logic [TIME_W-1:0]  INTV_FLOOR = 32'd500;
    localparam logic [TIME_W-1:0]  INTV_MAX   = 32'd60000;
    localparam logic [Q_NUM_W-1:0] Q_NUM      = 16'd60000;
    localparam logic [DEN_W-1:0]   RATE_DIV   = 28'd20;
    localparam logic [DEN_W-1:0]   DIV_FIFTH  = 28'd5;
    localparam logic [DEN_W-1:0]   DIV_SIXTH  = 28'd6;

    localparam logic [RATE_W-1:0] R_100 = 23'd6553600;
    localparam logic [RATE_W-1:0] R_75  = 23'd4915200;
    localparam logic [RATE_W-1:0] R_50  = 23'd3276800;
    localparam logic [RATE_W-1:0] R_25  = 23'd1638400;
    localparam logic [RATE_W-1:0] R_20  = 23'd1310720;
    localparam logic [RATE_W-1:0] R_15  = 23'd983040;
    localparam logic [RATE_W-1:0] R_7   = 23'd458752;
    localparam logic [RATE_W-1:0] R_4   = 23'd262144;

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now_ms;
        logic [DIFF_W-1:0] requested_difficulty;
    } evt_t;

    typedef struct packed {
        logic              changed;
        logic [DIFF_W-1:0] difficulty;
        logic [RATE_W-1:0] share_rate;
    } res_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] num;
        logic [DEN_W-1:0]  den;
        logic [CNT_W-1:0]  iters;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_RATE,
        ST_PROP,
        ST_CLAMP,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        STEP_X4,
        STEP_X7H,
        STEP_X3,
        STEP_X2,
        STEP_X3H,
        STEP_X6D5,
        STEP_HALF,
        STEP_X5D6
    } step_t;

    typedef enum logic [1:0] {
        DIV_Q,
        DIV_RATE,
        DIV_LADDER,
        DIV_NORM
    } div_op_t;

endpackage

@@ sv/srdc_div.sv @@
module srdc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srdc_pkg::div_req_t                  req,
    output logic [srdc_pkg::PROD_W-1:0]         quo,
    output logic [srdc_pkg::DEN_W-1:0]          rem,
    output logic                                done
);
    import srdc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PROD_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W:0]      trial;
    logic [DEN_W:0]      diff;
    logic                ge;

    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, one quotient bit out
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next = {num_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign quo  = num_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with zero count");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

@@ sv/share_rate_difficulty_controller_top.sv @@
// Variable share difficulty for one client. Each transaction (share, adjust or change request)
// yields exactly one result with the current difficulty and Q7.16 share rate. A share under remote
// override, or the unused mode, goes straight from decode to done. A change to a value below one
// unit skips the divider, a change above one unit and the minimum uses it for the floor to
// multiples of two units, and the longest path is a ladder step by 6/5 or 5/6 followed by that
// floor. A share skips the 60000/interval quotient when the interval exceeds 60000 ms.
// The bit-serial divider gives one quotient bit per cycle and is
// shared by the 60000/interval quotient (16 bits), the rate smoothing divide by 20
// (28 bits), the fifth and sixth ladder steps and the floor to multiples of two units (56 bits
// each). The next transaction is taken once the sequencer is back in idle. A result still held
// in the output register keeps the sequencer in its last state.
module share_rate_difficulty_controller_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                evt_valid,
    output logic                                evt_stall,
    input  srdc_pkg::evt_t                      evt,
    output logic                                res_valid,
    input  logic                                res_stall,
    output srdc_pkg::res_t                      res,
    input  logic                                cfg_wr_en,
    input  logic [srdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srdc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import srdc_pkg::*;

    state_t              state_reg, state_next;
    evt_t                evt_reg, evt_next;
    res_t                res_reg, res_next;
    logic                res_valid_reg, res_valid_next;
    logic                changed_reg, changed_next;
    logic [DIFF_W-1:0]   cur_reg, cur_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [PROD_W-1:0]   p_reg, p_next;
    logic [Q_W-1:0]      q_reg, q_next;
    step_t               step_reg, step_next;
    div_op_t             div_op_reg, div_op_next;

    logic [DIFF_W-1:0]   min_reg, max_reg, remote_reg;
    logic                fixed_reg;
    logic [RATE_W-1:0]   rate_reset_reg;

    div_req_t            div_req;
    logic [PROD_W-1:0]   div_quo;
    logic [DEN_W-1:0]    div_rem;
    logic                div_done;

    logic [TIME_W-1:0]     diff;
    logic [TIME_W-1:0]     intv;
    logic                  intv_big;
    logic                  remote_on;
    step_t                 step_sel;
    logic                  step_none;
    logic [PROD_W-1:0]     d_ext;
    logic [PROD_W-1:0]     prod;
    logic [RATE_SUM_W-1:0] rate_ext;
    logic [RATE_SUM_W-1:0] rate_sum;
    logic [PROD_W-1:0]     min_ext, max_ext;
    logic                  p_zero, p_lt_min, p_lt_one, p_gt_one, p_gt_max;
    logic                  commit_take;
    logic                  res_free;
    logic                  rate_out_band;

    srdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .quo   (div_quo),
        .rem   (div_rem),
        .done  (div_done)
    );

    assign diff      = evt_reg.now_ms - last_reg;
    assign intv      = (diff < INTV_FLOOR) ? INTV_FLOOR : diff;
    assign intv_big  = intv > INTV_MAX;
    assign remote_on = remote_reg != '0;
    assign d_ext     = {{(PROD_W-DIFF_W){1'b0}}, cur_reg};
    assign min_ext   = {{(PROD_W-DIFF_W){1'b0}}, min_reg};
    assign max_ext   = {{(PROD_W-DIFF_W){1'b0}}, max_reg};
    assign rate_ext  = {{(RATE_SUM_W-RATE_W){1'b0}}, rate_reg};
    assign rate_sum  = (rate_ext << 4) + (rate_ext << 1) + rate_ext
                     + {{(RATE_SUM_W-Q_W-16){1'b0}}, q_reg, 16'b0};

    assign p_zero      = p_reg == '0;
    assign p_lt_min    = p_reg < min_ext;
    assign p_lt_one    = p_reg < ONE_UNIT;
    assign p_gt_one    = p_reg > ONE_UNIT;
    assign p_gt_max    = p_reg > max_ext;
    assign commit_take = !p_zero && (p_reg != d_ext);
    assign res_free    = !res_valid_reg || !res_stall;
    assign rate_out_band = (rate_reg < R_7) || (rate_reg > R_15);

    always_comb
    begin
        step_sel  = STEP_X4;
        step_none = 1'b0;
        if (rate_reg > R_100)
            step_sel = STEP_X4;
        else if (fixed_reg)
            step_none = 1'b1;
        else if (rate_reg > R_75)
            step_sel = STEP_X7H;
        else if (rate_reg > R_50)
            step_sel = STEP_X3;
        else if (rate_reg > R_25)
            step_sel = STEP_X2;
        else if (rate_reg > R_20)
            step_sel = STEP_X3H;
        else if (rate_reg > R_15)
            step_sel = STEP_X6D5;
        else if (rate_reg < R_4)
            step_sel = STEP_HALF;
        else if (rate_reg < R_7)
            step_sel = STEP_X5D6;
        else
            step_none = 1'b1;
    end

    always_comb
    begin
        case (step_reg)
            STEP_X4:   prod = d_ext << 2;
            STEP_X7H:  prod = (d_ext << 3) - d_ext;
            STEP_X3:   prod = (d_ext << 1) + d_ext;
            STEP_X2:   prod = d_ext << 1;
            STEP_X3H:  prod = (d_ext << 1) + d_ext;
            STEP_X6D5: prod = (d_ext << 2) + (d_ext << 1);
            STEP_HALF: prod = d_ext;
            STEP_X5D6: prod = (d_ext << 2) + d_ext;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                unique case (evt_reg.mode)
                    MODE_SHARE:
                    begin
                        if (remote_on)
                            state_next = ST_DONE;
                        else if (intv_big)
                            state_next = ST_RATE;
                        else
                            state_next = ST_DIV;
                    end
                    MODE_ADJUST:
                    begin
                        if (remote_on)
                            state_next = ST_PROP;
                        else if (step_none)
                            state_next = ST_DONE;
                        else
                            state_next = ST_MUL;
                    end
                    MODE_CHANGE: state_next = ST_PROP;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_MUL:
            begin
                if (step_reg == STEP_X6D5 || step_reg == STEP_X5D6)
                    state_next = ST_DIV;
                else
                    state_next = ST_PROP;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    unique case (div_op_reg)
                        DIV_Q:      state_next = ST_RATE;
                        DIV_RATE:   state_next = ST_DONE;
                        DIV_LADDER: state_next = ST_PROP;
                        DIV_NORM:   state_next = ST_CLAMP;
                    endcase
                end
            end
            ST_RATE: state_next = ST_DIV;
            ST_PROP:
            begin
                if (p_zero)
                    state_next = ST_DONE;
                else if (!p_lt_min && !p_lt_one && p_gt_one)
                    state_next = ST_DIV;
                else
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        evt_next       = evt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        changed_next   = changed_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        rate_next      = rate_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        step_next      = step_reg;
        div_op_next    = div_op_reg;
        div_req        = '0;

        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                    evt_next = evt;
            end
            ST_DECODE:
            begin
                changed_next = 1'b0;
                unique case (evt_reg.mode)
                    MODE_SHARE:
                    begin
                        last_next = evt_reg.now_ms;
                        if (!remote_on)
                        begin
                            if (intv_big)
                                q_next = '0;
                            else
                            begin
                                div_req.start = 1'b1;
                                div_req.num   = {Q_NUM, {(PROD_W-Q_NUM_W){1'b0}}};
                                div_req.den   = intv[DEN_W-1:0];
                                div_req.iters = CNT_W'(Q_NUM_W);
                                div_op_next   = DIV_Q;
                            end
                        end
                    end
                    MODE_ADJUST:
                    begin
                        if (remote_on)
                            p_next = {{(PROD_W-DIFF_W){1'b0}}, remote_reg};
                        else
                            step_next = step_sel;
                    end
                    MODE_CHANGE:
                        p_next = {{(PROD_W-DIFF_W){1'b0}}, evt_reg.requested_difficulty};
                    default: ;
                endcase
            end
            ST_MUL:
            begin
                case (step_reg) inside
                    STEP_X7H, STEP_X3H, STEP_HALF: p_next = prod >> 1;
                    STEP_X6D5, STEP_X5D6:
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = prod;
                        div_req.den   = (step_reg == STEP_X6D5) ? DIV_FIFTH : DIV_SIXTH;
                        div_req.iters = CNT_W'(PROD_W);
                        div_op_next   = DIV_LADDER;
                    end
                    default: p_next = prod;
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    unique case (div_op_reg)
                        DIV_Q:      q_next    = div_quo[Q_W-1:0];
                        DIV_RATE:   rate_next = div_quo[RATE_W-1:0];
                        DIV_LADDER: p_next    = div_quo;
                        DIV_NORM:
                            p_next = p_reg - {{(PROD_W-DEN_W){1'b0}}, div_rem};
                    endcase
                end
            end
            ST_RATE:
            begin
                div_req.start = 1'b1;
                div_req.num   = {rate_sum, {(PROD_W-RATE_SUM_W){1'b0}}};
                div_req.den   = RATE_DIV;
                div_req.iters = CNT_W'(RATE_SUM_W);
                div_op_next   = DIV_RATE;
            end
            ST_PROP:
            begin
                if (!p_zero)
                begin
                    if (p_lt_min)
                        p_next = min_ext;
                    else if (p_lt_one)
                        p_next = {p_reg[PROD_W-1:1], 1'b0};
                    else if (p_gt_one)
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = p_reg;
                        div_req.den   = TWO_UNITS;
                        div_req.iters = CNT_W'(PROD_W);
                        div_op_next   = DIV_NORM;
                    end
                end
            end
            ST_CLAMP:
            begin
                if (p_gt_max)
                    p_next = max_ext;
            end
            ST_COMMIT:
            begin
                if (commit_take)
                begin
                    cur_next     = p_reg[DIFF_W-1:0];
                    changed_next = 1'b1;
                    if (rate_out_band)
                        rate_next = rate_reset_reg;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    res_next.changed    = changed_reg;
                    res_next.difficulty = cur_reg;
                    res_next.share_rate = rate_reg;
                    res_valid_next      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            cur_reg       <= '0;
            last_reg      <= '0;
            rate_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            cur_reg       <= cur_next;
            last_reg      <= last_next;
            rate_reg      <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg     <= evt_next;
        res_reg     <= res_next;
        changed_reg <= changed_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        step_reg    <= step_next;
        div_op_reg  <= div_op_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg        <= '0;
            max_reg        <= MAX_DIFF_RESET;
            remote_reg     <= '0;
            fixed_reg      <= 1'b0;
            rate_reset_reg <= RATE_RESET_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MIN_DIFFICULTY:    min_reg        <= cfg_wdata[DIFF_W-1:0];
                CFG_MAX_DIFFICULTY:    max_reg        <= cfg_wdata[DIFF_W-1:0];
                CFG_REMOTE_DIFFICULTY: remote_reg     <= cfg_wdata[DIFF_W-1:0];
                CFG_FIXED_MODE:        fixed_reg      <= cfg_wdata[0];
                CFG_RATE_RESET_VALUE:  rate_reset_reg <= cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    assign evt_stall = state_reg != ST_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_stall) |=> (state_reg == ST_DECODE))
        else $error("transaction accepted without leaving idle");
    a_commit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> (p_reg <= max_ext))
        else $error("proposal above maximum at commit");
    a_adopt_changes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && commit_take) |=> (cur_reg != $past(cur_reg)))
        else $error("adopted difficulty equals previous difficulty");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import srdc_pkg::*;

    localparam int          HOLD_CYCLES  = 400;
    localparam int          IDLE_LIMIT   = 5000;
    localparam int          DRAIN_CYCLES = 150;
    localparam int          PHASES       = 15;
    localparam int          PHASE_EVENTS = 60;
    localparam logic [1:0]  MODE_NONE    = 2'd3;
    localparam logic [63:0] UNIT         = 64'd100000000;
    localparam logic [63:0] RATE_ONE     = 64'd65536;
    localparam logic [52:0] DIFF_ALL     = '1;
    localparam logic [22:0] RATE_ALL     = '1;

    typedef enum bit {
        ROW_EVT,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [1:0]             mode;
        logic [TIME_W-1:0]      now;
        logic [DIFF_W-1:0]      val;
        logic                   chk;
        res_t                   want;
    } row_t;

    localparam int DIRECTED_ROWS = 35;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_ADJUST, 32'd0, 53'd0, 1'b1, '{1'b0, 53'd0, 23'd0}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd0, 1'b1, '{1'b0, 53'd0, 23'd0}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd1, 1'b1, '{1'b0, 53'd0, 23'd0}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_NONE, '1, DIFF_ALL, 1'b1, '{1'b0, 53'd0, 23'd0}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd2, 1'b1,
          '{1'b1, 53'd2, 23'd655360}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd2, 1'b1,
          '{1'b0, 53'd2, 23'd655360}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd100000000, 1'b1,
          '{1'b1, 53'd100000000, 23'd655360}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd300000000, 1'b1,
          '{1'b1, 53'd200000000, 23'd655360}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, DIFF_ALL, 1'b1,
          '{1'b1, 53'd9007199200000000, 23'd655360}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_SHARE, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_SHARE, 32'd1000, 53'd0, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_SHARE, 32'd500, 53'd0, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_SHARE, '1, 53'd0, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_SHARE, 32'd499, 53'd0, 1'b0, '0},
        '{ROW_CFG, CFG_MAX_DIFFICULTY, MODE_SHARE, 32'd0, 53'd99999999, 1'b0, '0},
        '{ROW_CFG, CFG_RATE_RESET_VALUE, MODE_SHARE, 32'd0, 53'd6619137, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd500000000, 1'b0, '0},
        '{ROW_CFG, CFG_MIN_DIFFICULTY, MODE_SHARE, 32'd0, DIFF_ALL, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd3, 1'b0, '0},
        '{ROW_CFG, CFG_MIN_DIFFICULTY, MODE_SHARE, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_CFG, CFG_MAX_DIFFICULTY, MODE_SHARE, 32'd0, DIFF_ALL, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_ADJUST, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_CFG, CFG_FIXED_MODE, MODE_SHARE, 32'd0, 53'd1, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_ADJUST, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_CFG, CFG_RATE_RESET_VALUE, MODE_SHARE, 32'd0, 53'd5242880, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_CHANGE, 32'd0, 53'd200000000, 1'b1,
          '{1'b1, 53'd200000000, 23'd5242880}},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_ADJUST, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_CFG, CFG_FIXED_MODE, MODE_SHARE, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_ADJUST, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_CFG, CFG_REMOTE_DIFFICULTY, MODE_SHARE, 32'd0, 53'd123456789, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_SHARE, 32'd5000, 53'd0, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_ADJUST, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_CFG, CFG_REMOTE_DIFFICULTY, MODE_SHARE, 32'd0, 53'd2, 1'b0, '0},
        '{ROW_EVT, CFG_MIN_DIFFICULTY, MODE_ADJUST, 32'd0, 53'd0, 1'b0, '0},
        '{ROW_CFG, CFG_REMOTE_DIFFICULTY, MODE_SHARE, 32'd0, 53'd0, 1'b0, '0}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  evt_valid = 1'b0;
    logic                  evt_stall;
    evt_t                  evt       = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_t                  res;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [DIFF_W-1:0]     min_diff    = '0;
    logic [DIFF_W-1:0]     max_diff    = DIFF_ALL;
    logic [DIFF_W-1:0]     remote_diff = '0;
    logic                  fixed_on    = 1'b0;
    logic [RATE_W-1:0]     rate_reload = 23'd655360;
    logic [DIFF_W-1:0]     cur_diff    = '0;
    logic [TIME_W-1:0]     last_share  = '0;
    logic [RATE_W-1:0]     smooth_rate = '0;

    res_t                  expected_q[$];
    int                    errors    = 0;
    int                    quiet     = 0;
    bit                    hold_req  = 1'b0;
    int                    gap_max   = 16;
    int                    stall_max = 16;

    share_rate_difficulty_controller_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] norm_diff(logic [63:0] p);
        if (p < 64'(min_diff))
            p = 64'(min_diff);
        else if (p < UNIT)
            p = p & ~64'd1;
        else if (p > UNIT)
            p = (p / (2 * UNIT)) * (2 * UNIT);
        if (p > 64'(max_diff))
            p = 64'(max_diff);
        return p;
    endfunction

    function automatic bit propose_diff(logic [63:0] p);
        logic [63:0] n;
        if (p == 64'd0)
            return 1'b0;
        n = norm_diff(p);
        if (n == 64'd0 || n == 64'(cur_diff))
            return 1'b0;
        cur_diff = n[DIFF_W-1:0];
        if (64'(smooth_rate) < 7 * RATE_ONE || 64'(smooth_rate) > 15 * RATE_ONE)
            smooth_rate = rate_reload;
        return 1'b1;
    endfunction

    function automatic bit adjust_diff();
        logic [63:0] d;
        logic [63:0] r;
        d = 64'(cur_diff);
        r = 64'(smooth_rate);
        if (remote_diff != '0)
            return propose_diff(64'(remote_diff));
        if (r > 100 * RATE_ONE)
            return propose_diff(d * 4);
        if (fixed_on)
            return 1'b0;
        if (r > 75 * RATE_ONE)
            return propose_diff(d * 7 / 2);
        if (r > 50 * RATE_ONE)
            return propose_diff(d * 3);
        if (r > 25 * RATE_ONE)
            return propose_diff(d * 2);
        if (r > 20 * RATE_ONE)
            return propose_diff(d * 3 / 2);
        if (r > 15 * RATE_ONE)
            return propose_diff(d * 6 / 5);
        if (r < 4 * RATE_ONE)
            return propose_diff(d / 2);
        if (r < 7 * RATE_ONE)
            return propose_diff(d * 5 / 6);
        return 1'b0;
    endfunction

    function automatic res_t apply_event(evt_t e);
        res_t              r;
        logic [TIME_W-1:0] span;
        logic [63:0]       q;
        r = '0;
        case (e.mode)
            MODE_SHARE:
            begin
                if (remote_diff == '0)
                begin
                    span = e.now_ms - last_share;
                    if (span < 32'd500)
                        span = 32'd500;
                    q = 64'd60000 / 64'(span);
                    smooth_rate = 23'((64'd19 * 64'(smooth_rate) + (q << 16)) / 64'd20);
                end
                last_share = e.now_ms;
            end
            MODE_ADJUST: r.changed = adjust_diff();
            MODE_CHANGE: r.changed = propose_diff(64'(e.requested_difficulty));
            default: ;
        endcase
        r.difficulty = cur_diff;
        r.share_rate = smooth_rate;
        return r;
    endfunction

    function automatic logic [DIFF_W-1:0] pick_diff();
        case ($urandom_range(0, 5))
            0: return 53'($urandom_range(0, 1000));
            1: return 53'(UNIT) - 53'd3 + 53'($urandom_range(0, 6));
            2: return 53'($urandom_range(0, 400000000));
            3: return 53'($urandom_range(1, 50)) * 53'd200000000 + 53'($urandom_range(0, 3));
            4: return 53'({$urandom(), $urandom()});
            default: return cur_diff + 53'($urandom_range(0, 4)) - 53'd2;
        endcase
    endfunction

    task automatic drain();
        evt_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_MIN_DIFFICULTY:    min_diff    = val;
            CFG_MAX_DIFFICULTY:    max_diff    = val;
            CFG_REMOTE_DIFFICULTY: remote_diff = val;
            CFG_FIXED_MODE:        fixed_on    = val[0];
            CFG_RATE_RESET_VALUE:  rate_reload = val[RATE_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_event(input evt_t e, input logic chk, input res_t want);
        int   gap;
        res_t got;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt       <= e;
        evt_valid <= 1'b1;
        do @(posedge clk); while (evt_stall);
        got = apply_event(e);
        expected_q.push_back(chk ? want : got);
    endtask

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (res_valid && !res_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with none expected: expected none, got %0d/%0d/%0d",
                         $time, res.changed, res.difficulty, res.share_rate);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (res.changed !== want.changed)
                begin
                    $display("%0t: changed mismatch: expected %0d, got %0d",
                             $time, want.changed, res.changed);
                    errors++;
                end
                if (res.difficulty !== want.difficulty)
                begin
                    $display("%0t: difficulty mismatch: expected %0d, got %0d",
                             $time, want.difficulty, res.difficulty);
                    errors++;
                end
                if (res.share_rate !== want.share_rate)
                begin
                    $display("%0t: share_rate mismatch: expected %0d, got %0d",
                             $time, want.share_rate, res.share_rate);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet == IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            n = $urandom_range(0, stall_max);
            if (n != 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    initial
    begin : stimulus
        row_t              row;
        evt_t              e;
        logic [TIME_W-1:0] clock_ms;
        int                span_base;
        int                pick;
        logic [DIFF_W-1:0] lo_v;
        logic [DIFF_W-1:0] hi_v;
        logic [DIFF_W-1:0] rem_v;
        logic [DIFF_W-1:0] swap_v;
        logic              fix_v;
        logic [RATE_W-1:0] rel_v;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
                write_reg(row.idx, row.val);
            else
            begin
                e.mode                 = row.mode;
                e.now_ms               = row.now;
                e.requested_difficulty = row.val;
                send_event(e, row.chk, row.want);
            end
        end

        clock_ms = 32'd20000;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lo_v  = '0;
                    hi_v  = DIFF_ALL;
                    rem_v = '0;
                    fix_v = 1'b0;
                    rel_v = '0;
                end
                1:
                begin
                    lo_v  = DIFF_ALL;
                    hi_v  = DIFF_ALL;
                    rem_v = '0;
                    fix_v = 1'b1;
                    rel_v = RATE_ALL;
                end
                2:
                begin
                    lo_v  = '0;
                    hi_v  = '0;
                    rem_v = '0;
                    fix_v = 1'b0;
                    rel_v = 23'd655360;
                end
                default:
                begin
                    lo_v  = ($urandom_range(0, 2) == 0) ? '0 : pick_diff();
                    hi_v  = ($urandom_range(0, 2) == 0) ? DIFF_ALL : pick_diff();
                    rem_v = ($urandom_range(0, 4) == 0) ? pick_diff() : '0;
                    fix_v = 1'($urandom_range(0, 1));
                    if ($urandom_range(0, 3) == 0)
                        rel_v = 23'($urandom());
                    else
                        rel_v = 23'(RATE_ONE * $urandom_range(0, 110) + $urandom_range(0, 65535));
                    if (lo_v > hi_v && $urandom_range(0, 1) == 1)
                    begin
                        swap_v = lo_v;
                        lo_v   = hi_v;
                        hi_v   = swap_v;
                    end
                end
            endcase
            write_reg(CFG_MIN_DIFFICULTY, lo_v);
            write_reg(CFG_MAX_DIFFICULTY, hi_v);
            write_reg(CFG_REMOTE_DIFFICULTY, rem_v);
            write_reg(CFG_FIXED_MODE, 53'(fix_v));
            write_reg(CFG_RATE_RESET_VALUE, 53'(rel_v));

            gap_max   = (p % 4 == 1) ? 0 : 16;
            stall_max = (p % 5 == 2) ? 0 : 16;
            // hold the result side while items keep coming
            if (p == 3)
            begin
                gap_max  = 0;
                hold_req = 1'b1;
            end
            span_base = $urandom_range(450, 15000);

            for (int k = 0; k < PHASE_EVENTS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    e.mode = MODE_SHARE;
                else if (pick < 80)
                    e.mode = MODE_ADJUST;
                else if (pick < 96)
                    e.mode = MODE_CHANGE;
                else
                    e.mode = MODE_NONE;
                e.requested_difficulty = pick_diff();
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    clock_ms = clock_ms + 32'($urandom_range(0, 499));
                else if (pick == 1)
                    clock_ms = $urandom();
                else
                    clock_ms = clock_ms + 32'(span_base * $urandom_range(75, 125) / 100);
                e.now_ms = clock_ms;
                send_event(e, 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/srdc_pkg.sv
sv/srdc_div.sv
sv/share_rate_difficulty_controller_top.sv
tb/testbench.sv
